// ===== sv/psag_pkg.sv =====
// psag_pkg: shared types, constants and helpers for the strided address generator.
// Used by psag_stride_cell, psag_lane and permuted_stride_address_gen; no dependencies.
`default_nettype none

package psag_pkg;

  localparam int NDIM          = 4;
  localparam int MAX_RANK      = 4;
  localparam int INDEX_WIDTH   = 16;
  localparam int SIZE_WIDTH    = 16;
  localparam int ADDR_WIDTH    = 32;
  localparam int PROD_WIDTH    = ADDR_WIDTH + 1;
  localparam int RANK_WIDTH    = 3;
  localparam int ORDER_WIDTH   = 8;
  localparam int DIM_IDX_WIDTH = $clog2(NDIM);
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;

  // cycles the stride chain needs to settle after a register write
  localparam int RECALC_CYCLES = NDIM + 1;
  localparam int CNT_WIDTH     = $clog2(RECALC_CYCLES + 1);

  localparam logic [RANK_WIDTH-1:0]  RANK_RESET  = RANK_WIDTH'(2);
  localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = ORDER_WIDTH'(27);
  localparam logic [SIZE_WIDTH-1:0]  SIZE_RESET  = SIZE_WIDTH'(1);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_RANK  = 3'd0,
    REG_ORDER = 3'd1,
    REG_SIZE0 = 3'd2,
    REG_SIZE1 = 3'd3,
    REG_SIZE2 = 3'd4,
    REG_SIZE3 = 3'd5
  } cfg_reg_t;

  // running product handed from cell to cell
  typedef struct packed {
    logic [PROD_WIDTH-1:0] prod;  // product modulo 2^PROD_WIDTH
    logic                  ovf;   // product went above 2^ADDR_WIDTH
  } link_t;

  // rank 0 acts as 1, anything above the limit is clamped
  function automatic logic [RANK_WIDTH-1:0] active_rank(input logic [RANK_WIDTH-1:0] rank);
    logic [RANK_WIDTH-1:0] r;
    r = rank;
    if (r == '0) r = RANK_WIDTH'(1);
    if (r > RANK_WIDTH'(MAX_RANK)) r = RANK_WIDTH'(MAX_RANK);
    if (r > RANK_WIDTH'(NDIM)) r = RANK_WIDTH'(NDIM);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/psag_stride_cell.sv =====
// psag_stride_cell: one link of the stride chain, multiplies the running product by one size.
// Depends on psag_pkg.
`default_nettype none

module psag_stride_cell
  import psag_pkg::*;
(
  input  wire logic                  clk,
  input  wire link_t                 link_i,
  input  wire logic [SIZE_WIDTH-1:0] size_i,
  output link_t                      link_o
);

  localparam int FULL_WIDTH = PROD_WIDTH + SIZE_WIDTH;
  localparam logic [FULL_WIDTH-1:0] LIMIT = FULL_WIDTH'(1) << ADDR_WIDTH;

  logic [FULL_WIDTH-1:0] full;
  link_t link_r, link_nxt;

  always_comb begin
    full          = FULL_WIDTH'(link_i.prod) * FULL_WIDTH'(size_i);
    link_nxt.prod = full[PROD_WIDTH-1:0];
    link_nxt.ovf  = link_i.ovf | (full > LIMIT);
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

  assign link_o = link_r;

endmodule

`default_nettype wire

// ===== sv/psag_lane.sv =====
// psag_lane: per-dimension index times stride product and range check, registered.
// Depends on psag_pkg.
`default_nettype none

module psag_lane
  import psag_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   active_i,
  input  wire logic [INDEX_WIDTH-1:0] index_i,
  input  wire logic [ADDR_WIDTH-1:0]  stride_i,
  input  wire logic [SIZE_WIDTH-1:0]  size_i,
  output logic      [ADDR_WIDTH-1:0]  prod_o,
  output logic                        oor_o
);

  localparam int FULL_WIDTH = INDEX_WIDTH + ADDR_WIDTH;

  logic [FULL_WIDTH-1:0] full;
  logic [ADDR_WIDTH-1:0] prod_r, prod_nxt;
  logic                  oor_r, oor_nxt;

  always_comb begin
    full     = FULL_WIDTH'(index_i) * FULL_WIDTH'(stride_i);
    prod_nxt = active_i ? full[ADDR_WIDTH-1:0] : '0;
    // a zero size puts every index out of range
    oor_nxt  = active_i & (32'(index_i) >= 32'(size_i));
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    oor_r  <= oor_nxt;
  end

  assign prod_o = prod_r;
  assign oor_o  = oor_r;

endmodule

`default_nettype wire

// ===== sv/permuted_stride_address_gen.sv =====
// permuted_stride_address_gen: top level of the strided tensor address generator.
// Depends on psag_pkg, psag_stride_cell and psag_lane.
//
// Usage: drive in_index_0..3 with start high; a word is taken at any edge where busy is
// low, one word per cycle sustained. Each result passes the lane and result registers
// and shows on the out_ ports for exactly one cycle, marked by out_valid; the receiver
// cannot stall it, so it must take every word. busy is high after reset and after every
// cfg_we write while the stride chain (decode, then one cell per order position) settles.
// Users must write registers only while no word is in flight; the block does not check.
`default_nettype none

module permuted_stride_address_gen
  import psag_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  // command side
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_0,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_1,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_2,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_3,
  // results
  output logic                           out_valid,
  output logic [ADDR_WIDTH-1:0]          out_linear_address,
  output logic                           out_index_out_of_range,
  output logic                           out_bad_order,
  output logic                           out_size_overflow
);

  // ---------------------------------------------------------------- config registers
  logic [RANK_WIDTH-1:0]  rank_r, rank_nxt;
  logic [ORDER_WIDTH-1:0] order_r, order_nxt;
  logic [SIZE_WIDTH-1:0]  size_r   [NDIM];
  logic [SIZE_WIDTH-1:0]  size_nxt [NDIM];
  logic [CNT_WIDTH-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    rank_nxt  = rank_r;
    order_nxt = order_r;
    size_nxt  = size_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RANK:  rank_nxt    = cfg_wdata[RANK_WIDTH-1:0];
        REG_ORDER: order_nxt   = cfg_wdata[ORDER_WIDTH-1:0];
        REG_SIZE0: size_nxt[0] = cfg_wdata[SIZE_WIDTH-1:0];
        REG_SIZE1: size_nxt[1] = cfg_wdata[SIZE_WIDTH-1:0];
        REG_SIZE2: size_nxt[2] = cfg_wdata[SIZE_WIDTH-1:0];
        REG_SIZE3: size_nxt[3] = cfg_wdata[SIZE_WIDTH-1:0];
        default:   ;  // unknown index: no effect
      endcase
    end
  end

  // settle counter: any write restarts it
  always_comb begin
    if (cfg_we) cnt_nxt = CNT_WIDTH'(RECALC_CYCLES);
    else if (cnt_r != '0) cnt_nxt = cnt_r - CNT_WIDTH'(1);
    else cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= RANK_RESET;
      order_r <= ORDER_RESET;
      for (int d = 0; d < NDIM; d++) size_r[d] <= SIZE_RESET;
      cnt_r   <= CNT_WIDTH'(RECALC_CYCLES);
    end else begin
      rank_r  <= rank_nxt;
      order_r <= order_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (cnt_r != '0);

  logic [RANK_WIDTH-1:0] act_rank;
  assign act_rank = active_rank(rank_r);

  // ---------------------------------------------------------------- order decode
  // Active entries must be a permutation of 0..rank-1, else fall back to row-major.
  logic [DIM_IDX_WIDTH-1:0] ord_r   [NDIM];
  logic [DIM_IDX_WIDTH-1:0] ord_nxt [NDIM];
  logic bad_r, bad_nxt;
  logic any_zero_r, any_zero_nxt;

  always_comb begin
    logic [DIM_IDX_WIDTH-1:0] raw [NDIM];
    logic [RANK_WIDTH-1:0]    rev;
    bad_nxt      = 1'b0;
    any_zero_nxt = 1'b0;
    for (int p = 0; p < NDIM; p++) begin
      raw[p] = order_r[DIM_IDX_WIDTH*p +: DIM_IDX_WIDTH];
    end
    for (int p = 0; p < NDIM; p++) begin
      if (RANK_WIDTH'(p) < act_rank) begin
        if (RANK_WIDTH'(raw[p]) >= act_rank) bad_nxt = 1'b1;
        for (int q = 0; q < p; q++) begin
          if (raw[q] == raw[p]) bad_nxt = 1'b1;
        end
        if (size_r[p] == '0) any_zero_nxt = 1'b1;
      end
    end
    for (int p = 0; p < NDIM; p++) begin
      rev        = act_rank - RANK_WIDTH'(p) - RANK_WIDTH'(1);
      ord_nxt[p] = bad_nxt ? rev[DIM_IDX_WIDTH-1:0] : raw[p];
    end
  end

  always_ff @(posedge clk) begin
    ord_r      <= ord_nxt;
    bad_r      <= bad_nxt;
    any_zero_r <= any_zero_nxt;
  end

  // ---------------------------------------------------------------- stride chain
  // Cell p multiplies the running product by the size of the dimension at order
  // position p; positions beyond the rank multiply by one.
  link_t                  link     [NDIM+1];
  logic [SIZE_WIDTH-1:0]  size_sel [NDIM];

  assign link[0].prod = PROD_WIDTH'(1);
  assign link[0].ovf  = 1'b0;

  for (genvar p = 0; p < NDIM; p++) begin : g_cell
    assign size_sel[p] = (RANK_WIDTH'(p) < act_rank) ? size_r[ord_r[p]] : SIZE_WIDTH'(1);

    psag_stride_cell u_cell (
      .clk    (clk),
      .link_i (link[p]),
      .size_i (size_sel[p]),
      .link_o (link[p+1])
    );
  end

  // stride at position p is the product of all faster sizes; scatter to dimensions
  logic [ADDR_WIDTH-1:0] stride_r   [NDIM];
  logic [ADDR_WIDTH-1:0] stride_nxt [NDIM];

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      stride_nxt[d] = ADDR_WIDTH'(1);
      for (int p = 0; p < NDIM; p++) begin
        if ((RANK_WIDTH'(p) < act_rank) && (ord_r[p] == DIM_IDX_WIDTH'(d))) begin
          stride_nxt[d] = link[p].prod[ADDR_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    stride_r <= stride_nxt;
  end

  // ---------------------------------------------------------------- address lanes
  logic [INDEX_WIDTH-1:0] in_index [NDIM];
  logic [ADDR_WIDTH-1:0]  lane_prod [NDIM];
  logic [NDIM-1:0]        lane_oor;

  assign in_index[0] = in_index_0;
  assign in_index[1] = in_index_1;
  assign in_index[2] = in_index_2;
  assign in_index[3] = in_index_3;

  for (genvar d = 0; d < NDIM; d++) begin : g_lane
    psag_lane u_lane (
      .clk      (clk),
      .active_i (RANK_WIDTH'(d) < act_rank),
      .index_i  (in_index[d]),
      .stride_i (stride_r[d]),
      .size_i   (size_r[d]),
      .prod_o   (lane_prod[d]),
      .oor_o    (lane_oor[d])
    );
  end

  // ---------------------------------------------------------------- result stage
  logic                  accept;
  logic                  s1_valid_r;
  logic                  out_valid_r;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic                  oor_r, bad_out_r, ovf_out_r;

  assign accept = start & ~busy;

  always_comb begin
    addr_nxt = '0;
    for (int d = 0; d < NDIM; d++) addr_nxt = addr_nxt + lane_prod[d];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    oor_r     <= |lane_oor;
    bad_out_r <= bad_r;
    // a zero size makes the total zero, so no overflow
    ovf_out_r <= link[NDIM].ovf & ~any_zero_r;
  end

  assign out_valid              = out_valid_r;
  assign out_linear_address     = addr_r;
  assign out_index_out_of_range = oor_r;
  assign out_bad_order          = bad_out_r;
  assign out_size_overflow      = ovf_out_r;

endmodule

`default_nettype wire

// ===== verif/psag_addr_checker.sv =====
// psag_addr_checker: predicts and scores each address word of permuted_stride_address_gen.
// Depends on psag_pkg; sits beside the DUT in permuted_stride_address_gen_tb.
`timescale 1ns / 100ps

module psag_addr_checker
  import psag_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_0,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_1,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_2,
  input  wire logic [INDEX_WIDTH-1:0]    in_index_3,
  input  wire logic                      out_valid,
  input  wire logic [ADDR_WIDTH-1:0]     out_linear_address,
  input  wire logic                      out_index_out_of_range,
  input  wire logic                      out_bad_order,
  input  wire logic                      out_size_overflow,
  output int                             mismatches,
  output int                             pending,
  output int                             checked
);

  localparam int REPORT_LIMIT = 10;

  typedef logic [NDIM-1:0][INDEX_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t                coord;
    logic [ADDR_WIDTH-1:0] addr;
    logic                  oor;
    logic                  bad_order;
    logic                  size_ovf;
  } addr_expect_t;

  logic [RANK_WIDTH-1:0]  rank_r;
  logic [ORDER_WIDTH-1:0] order_r;
  logic [SIZE_WIDTH-1:0]  extent [NDIM];
  logic [ADDR_WIDTH-1:0]  stride [NDIM];
  logic                   order_bad;
  logic                   total_ovf;
  addr_expect_t           addr_fifo [$];
  int                     fail_cnt = 0;
  int                     seen_cnt = 0;

  function automatic int live_rank();
    int r;
    r = rank_r;
    if (r == 0) r = 1;
    if (r > MAX_RANK) r = MAX_RANK;
    if (r > NDIM) r = NDIM;
    return r;
  endfunction

  task automatic derive_strides();
    int              r;
    logic [1:0]      dim_at [NDIM];
    logic [NDIM-1:0] taken;
    logic [63:0]     total;
    r = live_rank();
    taken = '0;
    order_bad = 1'b0;
    for (int p = 0; p < NDIM; p++) dim_at[p] = order_r[2*p +: 2];
    for (int p = 0; p < r; p++) begin
      if (dim_at[p] >= r || taken[dim_at[p]]) order_bad = 1'b1;
      else taken[dim_at[p]] = 1'b1;
    end
    // illegal order: row-major over the live dims
    if (order_bad)
      for (int p = 0; p < r; p++) dim_at[p] = 2'(r - 1 - p);
    for (int p = 0; p < NDIM; p++) stride[p] = 1;
    for (int p = 1; p < r; p++)
      stride[dim_at[p]] = stride[dim_at[p-1]] * extent[dim_at[p-1]];
    // four 16-bit extents fit in 64 bits exactly
    total = 64'd1;
    for (int p = 0; p < r; p++) total = total * extent[p];
    total_ovf = (total > 64'h1_0000_0000);
  endtask

  function automatic addr_expect_t predict_address(input coord_t c);
    addr_expect_t e;
    int           r;
    r = live_rank();
    e.coord = c;
    e.addr = '0;
    e.oor = 1'b0;
    for (int k = 0; k < r; k++) begin
      if (c[k] >= extent[k]) e.oor = 1'b1;
      e.addr = e.addr + c[k] * stride[k];
    end
    e.bad_order = order_bad;
    e.size_ovf = total_ovf;
    return e;
  endfunction

  always @(posedge clk) begin
    addr_expect_t want;
    if (!rst_n) begin
      rank_r = RANK_RESET;
      order_r = ORDER_RESET;
      for (int d = 0; d < NDIM; d++) extent[d] = SIZE_RESET;
      derive_strides();
      addr_fifo.delete();
    end else begin
      if (out_valid) begin
        if (addr_fifo.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("%0t: unexpected word: addr %h oor %b bad_order %b ovf %b", $time,
                     out_linear_address, out_index_out_of_range, out_bad_order,
                     out_size_overflow);
        end else begin
          want = addr_fifo.pop_front();
          seen_cnt++;
          if (out_linear_address !== want.addr || out_index_out_of_range !== want.oor ||
              out_bad_order !== want.bad_order || out_size_overflow !== want.size_ovf) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
              $display("%0t: word %0d idx %h: exp addr %h oor %b bad_order %b ovf %b, got %h %b %b %b",
                       $time, seen_cnt, want.coord, want.addr, want.oor, want.bad_order,
                       want.size_ovf, out_linear_address, out_index_out_of_range,
                       out_bad_order, out_size_overflow);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_RANK:  rank_r = cfg_wdata[RANK_WIDTH-1:0];
          REG_ORDER: order_r = cfg_wdata[ORDER_WIDTH-1:0];
          REG_SIZE0: extent[0] = cfg_wdata[SIZE_WIDTH-1:0];
          REG_SIZE1: extent[1] = cfg_wdata[SIZE_WIDTH-1:0];
          REG_SIZE2: extent[2] = cfg_wdata[SIZE_WIDTH-1:0];
          REG_SIZE3: extent[3] = cfg_wdata[SIZE_WIDTH-1:0];
          default: ;
        endcase
        derive_strides();
      end
      if (start && !busy)
        addr_fifo.push_back(predict_address({in_index_3, in_index_2, in_index_1, in_index_0}));
    end
    mismatches <= fail_cnt;
    pending <= addr_fifo.size();
    checked <= seen_cnt;
  end

endmodule

// ===== verif/permuted_stride_address_gen_tb.sv =====
// permuted_stride_address_gen_tb: stimulus, register setup and verdict for the address generator.
// Depends on psag_pkg, permuted_stride_address_gen and psag_addr_checker.
`timescale 1ns / 100ps

module permuted_stride_address_gen_tb;
  import psag_pkg::*;

  localparam int     WORDS_PER_PHASE = 48;
  localparam int     RANDOM_PHASES   = 11;
  localparam int     DRAIN_LIMIT     = 200;   // cycles to wait for outstanding words
  localparam int     TAIL_CYCLES     = 8;     // pipe is two deep, this is plenty
  localparam longint TIMEOUT_NS      = 4_000_000;

  // register indexes past the last one; writes there must be dropped
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

  // packed orders, position 0 (fastest) in bits 1:0
  localparam logic [ORDER_WIDTH-1:0] ORDER_ROW_MAJOR = 8'h1B;  // 3,2,1,0
  localparam logic [ORDER_WIDTH-1:0] ORDER_COL_MAJOR = 8'hE4;  // 0,1,2,3
  localparam logic [ORDER_WIDTH-1:0] ORDER_ALL_ZERO  = 8'h00;  // repeats dim 0
  localparam logic [ORDER_WIDTH-1:0] ORDER_HAS_DIM3  = 8'h36;  // 2,1,3: dim 3 past rank 3

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      cfg_we     = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index  = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata  = '0;
  logic                      start      = 1'b0;
  logic [INDEX_WIDTH-1:0]    in_index_0 = '0;
  logic [INDEX_WIDTH-1:0]    in_index_1 = '0;
  logic [INDEX_WIDTH-1:0]    in_index_2 = '0;
  logic [INDEX_WIDTH-1:0]    in_index_3 = '0;

  logic                      busy;
  logic                      out_valid;
  logic [ADDR_WIDTH-1:0]     out_linear_address;
  logic                      out_index_out_of_range;
  logic                      out_bad_order;
  logic                      out_size_overflow;

  int                        mismatches;
  int                        pending;
  int                        checked;

  // stimulus-side view of the extents, only used to aim indices near the edges
  logic [SIZE_WIDTH-1:0]     cur_extent [NDIM] = '{default: SIZE_RESET};
  int                        sent       = 0;
  int                        settings   = 0;
  int                        reg_writes = 0;
  bit                        idle_on    = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  permuted_stride_address_gen DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .start                  (start),
    .busy                   (busy),
    .in_index_0             (in_index_0),
    .in_index_1             (in_index_1),
    .in_index_2             (in_index_2),
    .in_index_3             (in_index_3),
    .out_valid              (out_valid),
    .out_linear_address     (out_linear_address),
    .out_index_out_of_range (out_index_out_of_range),
    .out_bad_order          (out_bad_order),
    .out_size_overflow      (out_size_overflow)
  );

  psag_addr_checker u_addr_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .start                  (start),
    .busy                   (busy),
    .in_index_0             (in_index_0),
    .in_index_1             (in_index_1),
    .in_index_2             (in_index_2),
    .in_index_3             (in_index_3),
    .out_valid              (out_valid),
    .out_linear_address     (out_linear_address),
    .out_index_out_of_range (out_index_out_of_range),
    .out_bad_order          (out_bad_order),
    .out_size_overflow      (out_size_overflow),
    .mismatches             (mismatches),
    .pending                (pending),
    .checked                (checked)
  );

  // Drop start for a while; the index ports carry junk meanwhile, which the
  // block must ignore.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    in_index_0 <= INDEX_WIDTH'($urandom);
    in_index_1 <= INDEX_WIDTH'($urandom);
    in_index_2 <= INDEX_WIDTH'($urandom);
    in_index_3 <= INDEX_WIDTH'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Present one word and hold it until an edge sees start high with busy low.
  // start stays up afterward unless hold_off drops it, so back-to-back words keep one per cycle.
  task automatic issue_coord(input logic [INDEX_WIDTH-1:0] i0, i1, i2, i3);
    start <= 1'b1;
    in_index_0 <= i0;
    in_index_1 <= i1;
    in_index_2 <= i2;
    in_index_3 <= i3;
    do @(posedge clk); while (busy);
    sent++;
    if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 13));
  endtask

  // Stop sending and wait until every word in flight has come back.
  // Bounded, so a lost word shows up as a leftover instead of a hang.
  task automatic quiesce();
    int waited;
    start <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
  endtask

  // One register write; busy rises while the strides settle, so wait it out.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_index <= CFG_IDX_WIDTH'($urandom);
    cfg_wdata <= CFG_DATA_WIDTH'($urandom);
    reg_writes++;
    do @(posedge clk); while (busy);
  endtask

  // Full register setup. Rank and order carry random junk above their width,
  // which the block has to mask off.
  task automatic program_regs(input logic [RANK_WIDTH-1:0] rk,
                              input logic [ORDER_WIDTH-1:0] ord,
                              input logic [SIZE_WIDTH-1:0] s0, s1, s2, s3);
    logic [CFG_DATA_WIDTH-1:0] junk;
    junk = CFG_DATA_WIDTH'($urandom);
    quiesce();
    write_reg(REG_RANK, {junk[CFG_DATA_WIDTH-1:RANK_WIDTH], rk});
    write_reg(REG_ORDER, {junk[CFG_DATA_WIDTH-1:ORDER_WIDTH], ord});
    write_reg(REG_SIZE0, CFG_DATA_WIDTH'(s0));
    write_reg(REG_SIZE1, CFG_DATA_WIDTH'(s1));
    write_reg(REG_SIZE2, CFG_DATA_WIDTH'(s2));
    write_reg(REG_SIZE3, CFG_DATA_WIDTH'(s3));
    cur_extent = '{s0, s1, s2, s3};
    settings++;
  endtask

  function automatic logic [SIZE_WIDTH-1:0] pick_extent();
    case ($urandom_range(0, 15))
      0:       return '0;                       // nothing in range
      1, 2:    return '1;
      3, 4:    return SIZE_WIDTH'($urandom);
      5:       return SIZE_WIDTH'(256);         // 256^4 sits right at 2^32
      default: return SIZE_WIDTH'($urandom_range(1, 24));
    endcase
  endfunction

  // Mostly in range, with the first index past the end and the extremes mixed in.
  function automatic logic [INDEX_WIDTH-1:0] pick_coord(input logic [SIZE_WIDTH-1:0] ext);
    case ($urandom_range(0, 11))
      0:       return INDEX_WIDTH'($urandom);
      1:       return INDEX_WIDTH'(ext);
      2:       return '1;
      3:       return '0;
      default: return (ext == 0) ? INDEX_WIDTH'($urandom)
                                 : INDEX_WIDTH'($urandom_range(0, ext - 1));
    endcase
  endfunction

  // Random setting: mostly a legal permutation over the live rank, sometimes
  // an out-of-range rank or a raw byte for the order.
  task automatic random_setting();
    logic [RANK_WIDTH-1:0]  rk;
    logic [ORDER_WIDTH-1:0] ord;
    logic [SIZE_WIDTH-1:0]  ext [NDIM];
    logic [1:0]             dims [NDIM];
    logic [1:0]             tmp;
    int                     live;
    int                     j;
    rk = ($urandom_range(0, 7) == 0) ? RANK_WIDTH'($urandom)
                                     : RANK_WIDTH'($urandom_range(1, NDIM));
    live = (rk == 0) ? 1 : (rk > NDIM) ? NDIM : rk;
    for (int d = 0; d < NDIM; d++) dims[d] = 2'(d);
    for (int d = live - 1; d > 0; d--) begin
      j = $urandom_range(0, d);
      tmp = dims[d];
      dims[d] = dims[j];
      dims[j] = tmp;
    end
    ord = ORDER_WIDTH'($urandom);
    if ($urandom_range(0, 4) != 0)
      for (int p = 0; p < live; p++) ord[2*p +: 2] = dims[p];
    for (int d = 0; d < NDIM; d++) ext[d] = pick_extent();
    program_regs(rk, ord, ext[0], ext[1], ext[2], ext[3]);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_WIDTH'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // strides are rebuilt after reset; busy covers that
    do @(posedge clk); while (busy);

    // Reset setting: rank 2 with order 3,2 is not a permutation, so the
    // flag is up and strides fall back to row-major.
    issue_coord('0, '0, '0, '0);
    issue_coord('1, '1, '1, '1);

    // Row-major 2x3x4x5: in range, every index at its extent, origin.
    program_regs(RANK_WIDTH'(4), ORDER_ROW_MAJOR, 16'd2, 16'd3, 16'd4, 16'd5);
    issue_coord(16'd1, 16'd2, 16'd3, 16'd4);
    issue_coord(16'd2, 16'd3, 16'd4, 16'd5);
    issue_coord('0, '0, '0, '0);

    // Column-major, all extents at max: total size overflows, addresses wrap.
    program_regs(RANK_WIDTH'(4), ORDER_COL_MAJOR, '1, '1, '1, '1);
    issue_coord('1, '1, '1, '1);
    issue_coord(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE);
    issue_coord(16'd1, '0, '0, '0);
    issue_coord('0, '0, '0, 16'd1);

    // 256^4 is exactly 2^32: no overflow, last element is all ones.
    program_regs(RANK_WIDTH'(4), ORDER_COL_MAJOR, 16'd256, 16'd256, 16'd256, 16'd256);
    issue_coord(16'd255, 16'd255, 16'd255, 16'd255);
    // one more on the slowest dim tips it over
    program_regs(RANK_WIDTH'(4), ORDER_COL_MAJOR, 16'd256, 16'd256, 16'd256, 16'd257);
    issue_coord('0, '0, '0, 16'd256);

    // Rank 0 acts as rank 1; upper indices must not matter.
    program_regs(RANK_WIDTH'(0), ORDER_COL_MAJOR, 16'd300, 16'd2, 16'd2, 16'd2);
    issue_coord(16'd5, '1, '1, '1);
    issue_coord(16'd300, '0, '0, '0);

    // Rank 7 clamps to 4; order repeating dim 0 is illegal.
    program_regs(RANK_WIDTH'(7), ORDER_ALL_ZERO, 16'd3, 16'd5, 16'd7, 16'd9);
    issue_coord(16'd2, 16'd4, 16'd6, 16'd8);
    issue_coord(16'd3, '0, '0, '0);

    // Zero extent on dim 1: every word is out of range, no size overflow.
    program_regs(RANK_WIDTH'(2), ORDER_COL_MAJOR, 16'd9, 16'd0, 16'd1, 16'd1);
    issue_coord('0, '0, '0, '0);
    issue_coord(16'd8, '1, '0, '0);

    // Rank 3 whose order names dim 3.
    program_regs(RANK_WIDTH'(3), ORDER_HAS_DIM3, 16'd4, 16'd5, 16'd6, 16'd7);
    issue_coord(16'd3, 16'd4, 16'd5, 16'd6);

    // Writes past the last register must leave the setting alone.
    quiesce();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    issue_coord(16'd1, 16'd1, 16'd1, 16'd1);

    // Random phases; each one drains the pipe before new registers go in.
    // Every third phase and the last one run back to back with no gaps.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting();
      idle_on = (ph % 3 != 2) && (ph != RANDOM_PHASES - 1);
      repeat (WORDS_PER_PHASE)
        issue_coord(pick_coord(cur_extent[0]), pick_coord(cur_extent[1]),
                    pick_coord(cur_extent[2]), pick_coord(cur_extent[3]));
    end

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words under %0d register settings, %0d register writes in all.",
             sent, settings, reg_writes);
    $display("Compared %0d words: %0d mismatched, %0d never came back.",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
